/* rtl/core/lfs_pkg.sv */
// Package for the Laplacian flux stencil: widths, payload structs and cell control type.
package lfs_pkg;

  // Width of the grid values and of the saturated Laplacians
  localparam int ValueWidth = 32;
  // Width of every field on the ports
  localparam int FieldWidth = 32;
  // Rows in one grid column and columns held in the window
  localparam int NumRows    = 5;
  localparam int HeldCols   = 4;
  // Exact Laplacian: 4*p minus four terms needs three guard bits
  localparam int LapWidth   = ValueWidth + 3;

  // Row positions inside a column
  localparam int RowTop    = 0;
  localparam int RowUpper  = 1;
  localparam int RowMiddle = 2;
  localparam int RowLower  = 3;
  localparam int RowBottom = 4;

  // Laplacian positions around the patch centre
  localparam int LapCentre = 0;
  localparam int LapWest   = 1;
  localparam int LapEast   = 2;
  localparam int LapNorth  = 3;
  localparam int LapSouth  = 4;
  localparam int NumLaps   = 5;

  typedef logic [NumRows-1:0][ValueWidth-1:0] lfs_col_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] top_value;
    logic signed [FieldWidth-1:0] upper_value;
    logic signed [FieldWidth-1:0] middle_value;
    logic signed [FieldWidth-1:0] lower_value;
    logic signed [FieldWidth-1:0] bottom_value;
    logic                         row_start;
  } lfs_in_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] flux_west;
    logic signed [FieldWidth-1:0] flux_east;
    logic signed [FieldWidth-1:0] flux_north;
    logic signed [FieldWidth-1:0] flux_south;
  } lfs_out_t;

  // Control type used by every cell of the window
  typedef struct packed {
    logic shift;
    logic clear;
  } lfs_cell_ctrl_t;

endpackage

/* rtl/core/lfs_column_cell.sv */
// One window cell: holds a grid column and its valid flag, takes its neighbour's on a shift.
module lfs_column_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lfs_pkg::lfs_cell_ctrl_t ctrl_i,
  input  lfs_pkg::lfs_col_t       col_i,
  input  logic                    valid_i,
  output lfs_pkg::lfs_col_t       col_o,
  output logic                    valid_o
);

  lfs_pkg::lfs_col_t col_q, col_d;
  logic              valid_q, valid_d;

  // Next contents: neighbour's column on a shift, emptied at start of row
  always_comb begin
    col_d   = col_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      col_d   = col_i;
      valid_d = valid_i & ~ctrl_i.clear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Column payload, no reset needed
  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  assign col_o   = col_q;
  assign valid_o = valid_q;

endmodule

/* rtl/core/lfs_laplacian.sv */
// Five-point Laplacian 4*p - n - s - w - e, saturated to the value width.
module lfs_laplacian (
  input  logic signed [lfs_pkg::ValueWidth-1:0] p_i,
  input  logic signed [lfs_pkg::ValueWidth-1:0] n_i,
  input  logic signed [lfs_pkg::ValueWidth-1:0] s_i,
  input  logic signed [lfs_pkg::ValueWidth-1:0] w_i,
  input  logic signed [lfs_pkg::ValueWidth-1:0] e_i,
  output logic signed [lfs_pkg::ValueWidth-1:0] lap_o
);

  localparam int GuardBits = lfs_pkg::LapWidth - lfs_pkg::ValueWidth + 1;

  logic signed [lfs_pkg::LapWidth-1:0] sum;
  logic        [GuardBits-1:0]         top_bits;
  logic                                in_range;

  // Exact sum in the widened format
  assign sum = (lfs_pkg::LapWidth'(p_i) <<< 2) - lfs_pkg::LapWidth'(n_i)
             - lfs_pkg::LapWidth'(s_i) - lfs_pkg::LapWidth'(w_i)
             - lfs_pkg::LapWidth'(e_i);

  // Fits when all bits from the value sign bit upwards agree
  assign top_bits = sum[lfs_pkg::LapWidth-1:lfs_pkg::ValueWidth-1];
  assign in_range = (top_bits == '0) || (top_bits == '1);

  // Clamp to the signed range on overflow
  always_comb begin
    if (in_range) begin
      lap_o = sum[lfs_pkg::ValueWidth-1:0];
    end else if (sum[lfs_pkg::LapWidth-1]) begin
      lap_o = {1'b1, {(lfs_pkg::ValueWidth-1){1'b0}}};
    end else begin
      lap_o = {1'b0, {(lfs_pkg::ValueWidth-1){1'b1}}};
    end
  end

endmodule

/* rtl/core/laplacian_flux_stencil_core.sv */
// Top level of the Laplacian flux stencil: column window, Laplacian stage and flux output register.
//
// The block takes one grid column per transaction and can accept a new column in every
// cycle; a chain of four column cells shifts on each accepted column. When four earlier
// columns are held and the new column does not start a row, five saturated Laplacians are
// formed and registered in the Laplacian register, and the four flux differences follow in the
// output register. The first four columns of a row (the one flagged row_start and the three
// after it) give no result. Back-pressure on the output stalls the two pipeline registers;
// new columns are taken as long as the Laplacian register is empty or moves on.
module laplacian_flux_stencil_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lfs_pkg::lfs_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lfs_pkg::lfs_out_t out_data_o
);

  localparam int VW = lfs_pkg::ValueWidth;
  localparam int NC = lfs_pkg::HeldCols;

  logic                    in_accept;
  lfs_pkg::lfs_col_t       new_col;
  lfs_pkg::lfs_col_t       cell_col [NC];
  logic [NC-1:0]           cell_valid;
  lfs_pkg::lfs_cell_ctrl_t cell_ctrl [NC];
  logic                    window_full;

  logic signed [VW-1:0] grid [lfs_pkg::NumRows][NC+1];
  logic signed [VW-1:0] lap  [lfs_pkg::NumLaps];

  logic signed [VW-1:0] lap_q [lfs_pkg::NumLaps];
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_load;

  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  lfs_pkg::lfs_out_t    out_data_q, out_data_d;
  logic signed [VW-1:0] d_west, d_east, d_north, d_south;

  assign in_accept = in_valid_i && in_ready_o;

  // New column: low value bits of each field
  assign new_col[lfs_pkg::RowTop]    = in_data_i.top_value[VW-1:0];
  assign new_col[lfs_pkg::RowUpper]  = in_data_i.upper_value[VW-1:0];
  assign new_col[lfs_pkg::RowMiddle] = in_data_i.middle_value[VW-1:0];
  assign new_col[lfs_pkg::RowLower]  = in_data_i.lower_value[VW-1:0];
  assign new_col[lfs_pkg::RowBottom] = in_data_i.bottom_value[VW-1:0];

  // Window chain, cell 0 oldest; the last cell takes the incoming column
  for (genvar k = 0; k < NC; k++) begin : g_cell
    if (k == NC - 1) begin : g_last
      assign cell_ctrl[k].shift = in_accept;
      assign cell_ctrl[k].clear = 1'b0;
      lfs_column_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (cell_ctrl[k]),
        .col_i   (new_col),
        .valid_i (1'b1),
        .col_o   (cell_col[k]),
        .valid_o (cell_valid[k])
      );
    end else begin : g_mid
      assign cell_ctrl[k].shift = in_accept;
      assign cell_ctrl[k].clear = in_data_i.row_start;
      lfs_column_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (cell_ctrl[k]),
        .col_i   (cell_col[k+1]),
        .valid_i (cell_valid[k+1]),
        .col_o   (cell_col[k]),
        .valid_o (cell_valid[k])
      );
    end
  end

  assign window_full = &cell_valid;

  // 5x5 patch: window columns then the new column
  always_comb begin
    for (int r = 0; r < lfs_pkg::NumRows; r++) begin
      for (int c = 0; c < NC; c++) begin
        grid[r][c] = cell_col[c][r];
      end
      grid[r][NC] = new_col[r];
    end
  end

  // Laplacians at the centre and its four neighbours
  lfs_laplacian u_lap_c (
    .p_i (grid[2][2]), .n_i (grid[1][2]), .s_i (grid[3][2]),
    .w_i (grid[2][1]), .e_i (grid[2][3]), .lap_o (lap[lfs_pkg::LapCentre])
  );
  lfs_laplacian u_lap_w (
    .p_i (grid[2][1]), .n_i (grid[1][1]), .s_i (grid[3][1]),
    .w_i (grid[2][0]), .e_i (grid[2][2]), .lap_o (lap[lfs_pkg::LapWest])
  );
  lfs_laplacian u_lap_e (
    .p_i (grid[2][3]), .n_i (grid[1][3]), .s_i (grid[3][3]),
    .w_i (grid[2][2]), .e_i (grid[2][4]), .lap_o (lap[lfs_pkg::LapEast])
  );
  lfs_laplacian u_lap_n (
    .p_i (grid[1][2]), .n_i (grid[0][2]), .s_i (grid[2][2]),
    .w_i (grid[1][1]), .e_i (grid[1][3]), .lap_o (lap[lfs_pkg::LapNorth])
  );
  lfs_laplacian u_lap_s (
    .p_i (grid[3][2]), .n_i (grid[2][2]), .s_i (grid[4][2]),
    .w_i (grid[3][1]), .e_i (grid[3][3]), .lap_o (lap[lfs_pkg::LapSouth])
  );

  // Pipeline enables
  assign out_load   = !out_valid_q || out_ready_i;
  assign s1_load    = !s1_valid_q || out_load;
  assign in_ready_o = s1_load;

  // Laplacian stage valid
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = in_accept && window_full && !in_data_i.row_start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      lap_q <= lap;
    end
  end

  // Flux differences, wrapped to the value width
  assign d_west  = lap_q[lfs_pkg::LapCentre] - lap_q[lfs_pkg::LapWest];
  assign d_east  = lap_q[lfs_pkg::LapEast]   - lap_q[lfs_pkg::LapCentre];
  assign d_north = lap_q[lfs_pkg::LapCentre] - lap_q[lfs_pkg::LapNorth];
  assign d_south = lap_q[lfs_pkg::LapSouth]  - lap_q[lfs_pkg::LapCentre];

  always_comb begin
    out_data_d.flux_west  = lfs_pkg::FieldWidth'(d_west);
    out_data_d.flux_east  = lfs_pkg::FieldWidth'(d_east);
    out_data_d.flux_north = lfs_pkg::FieldWidth'(d_north);
    out_data_d.flux_south = lfs_pkg::FieldWidth'(d_south);
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/core/lfs_checker.sv */
// Port-level checks for the Laplacian flux stencil, bound to the top level.
module lfs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input lfs_pkg::lfs_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input lfs_pkg::lfs_out_t out_data_o
);

  logic in_accept;
  assign in_accept = in_valid_i && in_ready_o && (in_data_i.row_start || 1'b1);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // A free output never blocks new columns
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

  // A fresh result comes from an accepted column that passed through the Laplacian register
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) && $past(rst_ni, 2) |-> $past(in_accept, 2))
    else $error("result transaction without a matching column");

endmodule

bind laplacian_flux_stencil_core lfs_checker u_lfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* tb/lfs_flux_checker.sv */
// Scoreboard for the Laplacian flux stencil: predicts each flux result and checks the output stream.
module lfs_flux_checker
  import lfs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  lfs_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  lfs_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  // Predictor state: held columns, oldest first, and how many are valid
  lfs_col_t col_window [HeldCols];
  int       held_cols;
  int       fail_total;
  // Working 5x5 patch, rows by columns, new column last
  longint   patch [NumRows][HeldCols+1];
  // Flux results still owed by the block, oldest first
  lfs_out_t flux_expect_q [$];

  // Grid value from its low ValueWidth bits, sign-extended
  function automatic longint widen(input logic [ValueWidth-1:0] raw);
    logic signed [ValueWidth-1:0] sval;
    sval = raw;
    return longint'(sval);
  endfunction

  // Five-point Laplacian, exact, then clamped to the signed value range
  function automatic longint sat_lap(input longint p, input longint n, input longint s,
                                     input longint w, input longint e);
    longint sum;
    longint hi;
    longint lo;
    sum = 4 * p - n - s - w - e;
    hi  = (longint'(1) <<< (ValueWidth - 1)) - 1;
    lo  = -hi - 1;
    if (sum > hi) return hi;
    if (sum < lo) return lo;
    return sum;
  endfunction

  // Difference wrapped to ValueWidth bits, then sign-extended to the port width
  function automatic logic signed [FieldWidth-1:0] wrap_diff(input longint a, input longint b);
    logic signed [ValueWidth-1:0] diff;
    diff = ValueWidth'(a - b);
    return FieldWidth'(diff);
  endfunction

  // One accepted column: clear the window on a start of row, form the result if the window is full, then shift it in
  task automatic advance_column(input lfs_in_t col);
    lfs_col_t fresh;
    lfs_out_t flux;
    longint   lap_c, lap_w, lap_e, lap_n, lap_s;
    fresh[RowTop]    = col.top_value[ValueWidth-1:0];
    fresh[RowUpper]  = col.upper_value[ValueWidth-1:0];
    fresh[RowMiddle] = col.middle_value[ValueWidth-1:0];
    fresh[RowLower]  = col.lower_value[ValueWidth-1:0];
    fresh[RowBottom] = col.bottom_value[ValueWidth-1:0];
    if (col.row_start) begin
      for (int c = 0; c < HeldCols; c++) col_window[c] = '0;
      held_cols = 0;
    end
    for (int r = 0; r < NumRows; r++) begin
      for (int c = 0; c < HeldCols; c++) patch[r][c] = widen(col_window[c][r]);
      patch[r][HeldCols] = widen(fresh[r]);
    end
    if (held_cols == HeldCols) begin
      lap_c = sat_lap(patch[2][2], patch[1][2], patch[3][2], patch[2][1], patch[2][3]);
      lap_w = sat_lap(patch[2][1], patch[1][1], patch[3][1], patch[2][0], patch[2][2]);
      lap_e = sat_lap(patch[2][3], patch[1][3], patch[3][3], patch[2][2], patch[2][4]);
      lap_n = sat_lap(patch[1][2], patch[0][2], patch[2][2], patch[1][1], patch[1][3]);
      lap_s = sat_lap(patch[3][2], patch[2][2], patch[4][2], patch[3][1], patch[3][3]);
      flux.flux_west  = wrap_diff(lap_c, lap_w);
      flux.flux_east  = wrap_diff(lap_e, lap_c);
      flux.flux_north = wrap_diff(lap_c, lap_n);
      flux.flux_south = wrap_diff(lap_s, lap_c);
      flux_expect_q.push_back(flux);
    end
    for (int c = 0; c < HeldCols - 1; c++) col_window[c] = col_window[c+1];
    col_window[HeldCols-1] = fresh;
    if (held_cols < HeldCols) held_cols++;
  endtask

  task automatic compare_field(input string name, input logic signed [FieldWidth-1:0] want,
                               input logic signed [FieldWidth-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_total++;
    end
  endtask

  task automatic check_flux(input lfs_out_t got);
    lfs_out_t want;
    if (flux_expect_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual west %0d east %0d north %0d south %0d",
               $time, got.flux_west, got.flux_east, got.flux_north, got.flux_south);
      fail_total++;
    end else begin
      want = flux_expect_q.pop_front();
      compare_field("flux_west", want.flux_west, got.flux_west);
      compare_field("flux_east", want.flux_east, got.flux_east);
      compare_field("flux_north", want.flux_north, got.flux_north);
      compare_field("flux_south", want.flux_south, got.flux_south);
    end
  endtask

  // Watch both channels; results are checked before the same edge's column is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < HeldCols; c++) col_window[c] = '0;
      held_cols = 0;
      fail_total = 0;
      flux_expect_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_flux(out_data_i);
      if (in_valid_i && in_ready_i) advance_column(in_data_i);
      fail_count_o <= fail_total;
      pending_o    <= flux_expect_q.size();
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top for the Laplacian flux stencil: clock, reset, column stimulus and verdict.
module tb;
  import lfs_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 1050;
  localparam logic signed [FieldWidth-1:0] ValMax = 32'sh7fffffff;
  localparam logic signed [FieldWidth-1:0] ValMin = 32'sh80000000;

  typedef enum int {ValFull, ValEdge, ValSmall} value_mix_e;
  typedef enum int {RecvOpen, RecvCoin, RecvSparse, RecvHold} recv_mode_e;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  lfs_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lfs_out_t out_data;
  int       fail_count;
  int       pending;
  int       cycle_count = 0;
  int       burst_left  = 0;

  laplacian_flux_stencil_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  lfs_flux_checker flux_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [FieldWidth-1:0] pick_value(input value_mix_e mix);
    case (mix)
      ValEdge: begin
        case ($urandom_range(0, 5))
          0: return ValMax;
          1: return ValMin;
          2: return '0;
          3: return -1;
          4: return 1;
          default: return $urandom;
        endcase
      end
      ValSmall: return int'($urandom_range(0, 64)) - 32;
      default:  return $urandom;
    endcase
  endfunction

  function automatic lfs_in_t random_column(input value_mix_e mix, input logic rs);
    lfs_in_t col;
    col.top_value    = pick_value(mix);
    col.upper_value  = pick_value(mix);
    col.middle_value = pick_value(mix);
    col.lower_value  = pick_value(mix);
    col.bottom_value = pick_value(mix);
    col.row_start    = rs;
    return col;
  endfunction

  // Checkerboard of the two extremes: every Laplacian saturates, fluxes wrap
  function automatic lfs_in_t checker_column(input int c, input int flip, input logic rs);
    lfs_in_t col;
    logic signed [FieldWidth-1:0] v [NumRows];
    for (int r = 0; r < NumRows; r++) v[r] = ((r + c + flip) % 2 == 0) ? ValMax : ValMin;
    col.top_value    = v[RowTop];
    col.upper_value  = v[RowUpper];
    col.middle_value = v[RowMiddle];
    col.lower_value  = v[RowLower];
    col.bottom_value = v[RowBottom];
    col.row_start    = rs;
    return col;
  endfunction

  function automatic lfs_in_t uniform_column(input logic signed [FieldWidth-1:0] v,
                                             input logic rs);
    lfs_in_t col;
    col.top_value    = v;
    col.upper_value  = v;
    col.middle_value = v;
    col.lower_value  = v;
    col.bottom_value = v;
    col.row_start    = rs;
    return col;
  endfunction

  // Offer one column in bursts with random gaps; returns at the accepting edge
  task automatic send_column(input lfs_in_t col);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= col;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Receiver stall pattern; one long hold-off early on fills the block
  initial begin
    recv_mode_e mode;
    int         span;
    int         segment;
    segment = 0;
    @(posedge clk_i);
    forever begin
      if (segment == 3 || $urandom_range(0, 19) == 0) mode = RecvHold;
      else mode = recv_mode_e'($urandom_range(0, 2));
      span = (mode == RecvHold) ? 150 : $urandom_range(10, 80);
      repeat (span) begin
        case (mode)
          RecvOpen:   out_ready <= 1'b1;
          RecvCoin:   out_ready <= 1'($urandom_range(0, 1));
          RecvSparse: out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= 1'b0;
        endcase
        @(posedge clk_i);
      end
      segment++;
    end
  end

  // Reset, directed columns, random rows, drain and verdict
  initial begin
    value_mix_e mix;
    int         row_len;
    int         sent;
    logic       rs;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first row straight from reset, no start flag: saturating checkerboard
    for (int c = 0; c < 6; c++) send_column(checker_column(c, 0, 1'b0));
    // start of row on a full window; flat field gives zero Laplacians
    send_column(uniform_column(ValMin, 1'b1));
    for (int c = 0; c < 5; c++) send_column(uniform_column(ValMin, 1'b0));
    // inverted checkerboard
    for (int c = 0; c < 6; c++) send_column(checker_column(c, 1, c == 0));
    for (int c = 0; c < 4; c++) send_column(random_column(ValFull, 1'b0));

    // mostly well-formed rows with random content, some short or unflagged
    sent = 0;
    while (sent < RandomItems) begin
      mix = value_mix_e'($urandom_range(0, 2));
      row_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      for (int c = 0; c < row_len; c++) begin
        rs = (c == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
        send_column(random_column(mix, rs));
        sent++;
      end
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
